[rtl/core/stt_pkg.sv]
// Shared constants, codes and byte-class functions of the source text tokenizer.
package stt_pkg;

  // Default widths of position and line counters
  localparam int POS_BITS_DEF  = 20;
  localparam int LINE_BITS_DEF = 16;

  // Result queue: up to three results per byte, four slots of storage
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  // Largest integer literal value
  localparam logic [30:0] INT_LIMIT = 31'h7FFF_FFFF;

  // Scan modes
  localparam logic [2:0] M_IDLE        = 3'd0;
  localparam logic [2:0] M_OP          = 3'd1;
  localparam logic [2:0] M_IDENT       = 3'd2;
  localparam logic [2:0] M_INT         = 3'd3;
  localparam logic [2:0] M_CHAR_OPEN   = 3'd4;
  localparam logic [2:0] M_CHAR_LETTER = 3'd5;
  localparam logic [2:0] M_STRING      = 3'd6;

  // Token kinds
  localparam logic [4:0] K_COLON   = 5'd0;
  localparam logic [4:0] K_SEMI    = 5'd1;
  localparam logic [4:0] K_ASSIGN  = 5'd2;
  localparam logic [4:0] K_EQ      = 5'd3;
  localparam logic [4:0] K_LBRACK  = 5'd4;
  localparam logic [4:0] K_RBRACK  = 5'd5;
  localparam logic [4:0] K_LBRACE  = 5'd6;
  localparam logic [4:0] K_RBRACE  = 5'd7;
  localparam logic [4:0] K_COMMA   = 5'd8;
  localparam logic [4:0] K_LPAREN  = 5'd9;
  localparam logic [4:0] K_RPAREN  = 5'd10;
  localparam logic [4:0] K_MINUS   = 5'd11;
  localparam logic [4:0] K_DEC     = 5'd12;
  localparam logic [4:0] K_NOT     = 5'd13;
  localparam logic [4:0] K_NE      = 5'd14;
  localparam logic [4:0] K_CARET   = 5'd15;
  localparam logic [4:0] K_STAR    = 5'd16;
  localparam logic [4:0] K_SLASH   = 5'd17;
  localparam logic [4:0] K_PERCENT = 5'd18;
  localparam logic [4:0] K_PLUS    = 5'd19;
  localparam logic [4:0] K_INC     = 5'd20;
  localparam logic [4:0] K_LT      = 5'd21;
  localparam logic [4:0] K_LE      = 5'd22;
  localparam logic [4:0] K_GT      = 5'd23;
  localparam logic [4:0] K_GE      = 5'd24;
  localparam logic [4:0] K_AND     = 5'd25;
  localparam logic [4:0] K_OR      = 5'd26;
  localparam logic [4:0] K_IDENT   = 5'd27;
  localparam logic [4:0] K_INT     = 5'd28;
  localparam logic [4:0] K_CHAR    = 5'd29;
  localparam logic [4:0] K_STRING  = 5'd30;
  localparam logic [4:0] K_EOF     = 5'd31;

  // Error codes
  localparam logic [2:0] E_NONE        = 3'd0;
  localparam logic [2:0] E_UNEXPECTED  = 3'd1;
  localparam logic [2:0] E_UNTERM_CHAR = 3'd2;
  localparam logic [2:0] E_OVERFLOW    = 3'd3;
  localparam logic [2:0] E_UNTERM_STR  = 3'd4;

  // Special bytes
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  // Pending operator decode
  typedef struct packed {
    logic [7:0] second;
    logic [4:0] dbl;
    logic [4:0] single;
    logic       has_single;
  } op_info_t;

  // Single-byte token decode
  typedef struct packed {
    logic [4:0] kind;
    logic       hit;
  } start_kind_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_ident(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_op_start(input logic [7:0] b);
    return b inside {"=", "-", "!", "+", "<", ">", CH_AMP, CH_BAR};
  endfunction

  function automatic op_info_t op_info(input logic [7:0] op);
    op_info_t r;
    r.has_single = 1'b1;
    case (op)
      "=": begin r.second = "="; r.dbl = K_EQ;  r.single = K_ASSIGN; end
      "-": begin r.second = "-"; r.dbl = K_DEC; r.single = K_MINUS;  end
      "!": begin r.second = "="; r.dbl = K_NE;  r.single = K_NOT;    end
      "+": begin r.second = "+"; r.dbl = K_INC; r.single = K_PLUS;   end
      "<": begin r.second = "="; r.dbl = K_LE;  r.single = K_LT;     end
      ">": begin r.second = "="; r.dbl = K_GE;  r.single = K_GT;     end
      CH_AMP: begin
        r.second = CH_AMP; r.dbl = K_AND; r.single = K_AND; r.has_single = 1'b0;
      end
      default: begin
        r.second = CH_BAR; r.dbl = K_OR; r.single = K_OR; r.has_single = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic start_kind_t start_kind(input logic [7:0] b);
    start_kind_t r;
    r.hit = 1'b1;
    case (b)
      ":":     r.kind = K_COLON;
      ";":     r.kind = K_SEMI;
      "[":     r.kind = K_LBRACK;
      "]":     r.kind = K_RBRACK;
      "{":     r.kind = K_LBRACE;
      "}":     r.kind = K_RBRACE;
      ",":     r.kind = K_COMMA;
      "(":     r.kind = K_LPAREN;
      ")":     r.kind = K_RPAREN;
      "^":     r.kind = K_CARET;
      "*":     r.kind = K_STAR;
      "/":     r.kind = K_SLASH;
      "%":     r.kind = K_PERCENT;
      default: begin r.kind = K_COLON; r.hit = 1'b0; end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/stt_result_fifo.sv]
// Result FIFO: loads up to three records, drains one per cycle on out_ready.
module stt_result_fifo import stt_pkg::*; #(
  parameter int W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [1:0]                    load_cnt,
  input  logic [MAX_RESULTS-1:0][W-1:0] load_data,
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [W-1:0]                  out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [QUEUE_DEPTH-1:0][W-1:0]   data_r, data_nxt;
  logic [CW-1:0]                   base;
  logic                            pop;
  logic [CW-1:0]                   slot;

  assign out_valid = (cnt_r != '0);
  assign out_data  = data_r[0];
  assign pop       = out_valid && out_ready;
  // accept a new burst only when a full one still fits
  assign room      = (cnt_r <= CW'(QUEUE_DEPTH - MAX_RESULTS));

  // shift down on pop, then append the burst behind what remains
  always_comb begin
    base     = cnt_r - CW'(pop);
    data_nxt = data_r;
    slot     = '0;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (pop) begin
        data_nxt[i] = data_r[i + 1];
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot = CW'(i) - base;
      if (load && (CW'(i) >= base) && (slot < CW'(load_cnt))) begin
        data_nxt[i] = load_data[slot[1:0]];
      end
    end
    cnt_nxt = load ? (base + CW'(load_cnt)) : base;
  end

  // clear count under reset, payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

[rtl/core/source_text_tokenizer.sv]
// Top level of the source text tokenizer: byte scanner and result queue.
// A token enters the result queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while out_ready is high and each byte yields
// at most one token; the one result port paces bytes with two or three results.
// Reset (rst_n low, synchronous): scanner idle, counters cleared, line count one,
// result queue empty.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_char_byte,
  input  logic                 in_last_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           out_token_kind,
  output logic [2:0]           out_error_code,
  output logic [POS_BITS-1:0]  out_token_pos,
  output logic [LINE_BITS-1:0] out_line_number,
  output logic [POS_BITS-1:0]  out_token_length,
  output logic [30:0]          out_int_value,
  output logic [7:0]           out_char_value,
  output logic                 out_last_result
);

  typedef struct packed {
    logic [4:0]           kind;
    logic [2:0]           err;
    logic [POS_BITS-1:0]  pos;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  len;
    logic [30:0]          ival;
    logic [7:0]           cval;
    logic                 last;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // scanner state
  logic [2:0]           mode_r, mode_nxt;
  logic [7:0]           op_r, op_nxt;
  logic [30:0]          acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [POS_BITS-1:0]  tlen_r, tlen_nxt;
  logic [7:0]           letter_r, letter_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  logic                              accept;
  logic                              room;
  logic [1:0]                        n;
  rec_t [MAX_RESULTS-1:0]            rec;
  logic [MAX_RESULTS-1:0][REC_W-1:0] rec_bits;
  logic [REC_W-1:0]                  out_bits;
  rec_t                              out_rec;

  logic [7:0]           b;
  logic [POS_BITS-1:0]  pos_inc;
  logic [POS_BITS-1:0]  pos_eof;
  logic                 fresh;
  op_info_t             cur_op;
  op_info_t             end_op;
  start_kind_t          sk;
  logic [34:0]          digit_sum;

  function automatic rec_t mk_rec(input logic [4:0] kind, input logic [2:0] err,
                                  input logic [POS_BITS-1:0] pos,
                                  input logic [LINE_BITS-1:0] line,
                                  input logic [POS_BITS-1:0] len,
                                  input logic [30:0] ival, input logic [7:0] cval);
    rec_t r;
    r.kind = kind;
    r.err  = err;
    r.pos  = pos;
    r.line = line;
    r.len  = len;
    r.ival = ival;
    r.cval = cval;
    r.last = 1'b0;
    return r;
  endfunction

  assign b        = in_char_byte;
  assign accept   = in_valid && in_ready;
  assign in_ready = room;
  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
  assign cur_op   = op_info(op_r);
  assign sk       = start_kind(b);
  // accumulator times ten plus the new digit, by shifts
  assign digit_sum = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {31'b0, b[3:0]};

  // scan one byte: next state and up to three results
  always_comb begin
    mode_nxt   = mode_r;
    op_nxt     = op_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    tlen_nxt   = tlen_r;
    letter_nxt = letter_r;
    line_nxt   = line_r;
    pos_nxt    = pos_inc;
    fresh      = 1'b1;
    n          = '0;
    rec        = '0;
    end_op     = op_info(op_r);
    pos_eof    = pos_inc;

    // close or extend the open construct
    case (mode_r)
      M_OP: begin
        mode_nxt = M_IDLE;
        if (b == cur_op.second) begin
          rec[n] = mk_rec(cur_op.dbl, E_NONE, pos_inc, line_r, '0, '0, '0);
          n      = n + 1'b1;
          fresh  = 1'b0;
        end else if (cur_op.has_single) begin
          rec[n] = mk_rec(cur_op.single, E_NONE, pos_r, line_r, '0, '0, '0);
          n      = n + 1'b1;
        end
      end
      M_IDENT: begin
        if (is_ident(b)) begin
          tlen_nxt = (tlen_r == '1) ? tlen_r : tlen_r + 1'b1;
          fresh    = 1'b0;
        end else begin
          rec[n]   = mk_rec(K_IDENT, E_NONE, pos_r, line_r, tlen_r, '0, '0);
          n        = n + 1'b1;
          mode_nxt = M_IDLE;
        end
      end
      M_INT: begin
        if (is_digit(b)) begin
          fresh = 1'b0;
          if (!ovf_r) begin
            if (digit_sum > {4'b0, INT_LIMIT}) begin
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = digit_sum[30:0];
            end
          end
        end else begin
          if (ovf_r) begin
            rec[n] = mk_rec(K_INT, E_OVERFLOW, pos_r, line_r, '0, '0, '0);
          end else begin
            rec[n] = mk_rec(K_INT, E_NONE, pos_r, line_r, '0, acc_r, '0);
          end
          n        = n + 1'b1;
          mode_nxt = M_IDLE;
        end
      end
      M_CHAR_OPEN: begin
        if (is_alpha(b)) begin
          letter_nxt = b;
          mode_nxt   = M_CHAR_LETTER;
          fresh      = 1'b0;
        end else begin
          mode_nxt = M_IDLE;
        end
      end
      M_CHAR_LETTER: begin
        mode_nxt = M_IDLE;
        if (b == CH_SQUOTE) begin
          rec[n] = mk_rec(K_CHAR, E_NONE, pos_r, line_r, '0, '0, letter_r);
          fresh  = 1'b0;
        end else begin
          rec[n] = mk_rec(K_CHAR, E_UNTERM_CHAR, pos_r, line_r, '0, '0, '0);
        end
        n = n + 1'b1;
      end
      M_STRING: begin
        fresh = 1'b0;
        if (b == CH_DQUOTE) begin
          rec[n]   = mk_rec(K_STRING, E_NONE, pos_inc, line_r, tlen_r, '0, '0);
          n        = n + 1'b1;
          mode_nxt = M_IDLE;
        end else if (b == CH_NEWLINE) begin
          line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
        end else begin
          tlen_nxt = (tlen_r == '1) ? tlen_r : tlen_r + 1'b1;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    // start a new construct from this byte
    if (fresh) begin
      if (sk.hit) begin
        rec[n] = mk_rec(sk.kind, E_NONE, pos_inc, line_r, '0, '0, '0);
        n      = n + 1'b1;
      end else if (is_op_start(b)) begin
        mode_nxt = M_OP;
        op_nxt   = b;
      end else if (b == CH_SQUOTE) begin
        mode_nxt = M_CHAR_OPEN;
      end else if (b == CH_DQUOTE) begin
        mode_nxt = M_STRING;
        tlen_nxt = '0;
      end else if (b == CH_SPACE) begin
        mode_nxt = mode_nxt;
      end else if (b == CH_NEWLINE) begin
        line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
      end else if (is_alpha(b) || (b == CH_UNDERSCORE)) begin
        mode_nxt = M_IDENT;
        tlen_nxt = POS_BITS'(1);
      end else if (is_digit(b)) begin
        mode_nxt = M_INT;
        acc_nxt  = {27'b0, b[3:0]};
        ovf_nxt  = 1'b0;
      end else begin
        rec[n] = mk_rec(K_COLON, E_UNEXPECTED, pos_inc, line_r, '0, '0, '0);
        n      = n + 1'b1;
      end
    end

    // flush at end of source, add end of file and restart
    if (in_last_char) begin
      end_op  = op_info(op_nxt);
      pos_eof = (pos_inc == '1) ? pos_inc : pos_inc + 1'b1;
      case (mode_nxt)
        M_OP: begin
          if (end_op.has_single) begin
            rec[n] = mk_rec(end_op.single, E_NONE, pos_inc, line_nxt, '0, '0, '0);
            n      = n + 1'b1;
          end
        end
        M_IDENT: begin
          rec[n] = mk_rec(K_IDENT, E_NONE, pos_inc, line_nxt, tlen_nxt, '0, '0);
          n      = n + 1'b1;
        end
        M_INT: begin
          if (ovf_nxt) begin
            rec[n] = mk_rec(K_INT, E_OVERFLOW, pos_inc, line_nxt, '0, '0, '0);
          end else begin
            rec[n] = mk_rec(K_INT, E_NONE, pos_inc, line_nxt, '0, acc_nxt, '0);
          end
          n = n + 1'b1;
        end
        M_CHAR_LETTER: begin
          rec[n] = mk_rec(K_CHAR, E_UNTERM_CHAR, pos_inc, line_nxt, '0, '0, '0);
          n      = n + 1'b1;
        end
        M_STRING: begin
          rec[n] = mk_rec(K_STRING, E_UNTERM_STR, pos_inc, line_nxt, '0, '0, '0);
          n      = n + 1'b1;
        end
        default: begin
          n = n;
        end
      endcase
      rec[n] = mk_rec(K_EOF, E_NONE, pos_eof, line_nxt, '0, '0, '0);
      n      = n + 1'b1;

      mode_nxt   = M_IDLE;
      op_nxt     = '0;
      acc_nxt    = '0;
      ovf_nxt    = 1'b0;
      tlen_nxt   = '0;
      letter_nxt = '0;
      pos_nxt    = '0;
      line_nxt   = LINE_BITS'(1);
    end

    // mark the final result of this byte
    if (n != '0) begin
      rec[2'(n - 1'b1)].last = 1'b1;
    end
  end

  // advance scanner state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      op_r     <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      tlen_r   <= '0;
      letter_r <= '0;
      pos_r    <= '0;
      line_r   <= LINE_BITS'(1);
    end else if (accept) begin
      mode_r   <= mode_nxt;
      op_r     <= op_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      tlen_r   <= tlen_nxt;
      letter_r <= letter_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      rec_bits[i] = rec[i];
    end
  end

  stt_result_fifo #(
    .W (REC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && (n != '0)),
    .load_cnt  (n),
    .load_data (rec_bits),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_bits)
  );

  // unpack the head record onto the result ports
  assign out_rec          = out_bits;
  assign out_token_kind   = out_rec.kind;
  assign out_error_code   = out_rec.err;
  assign out_token_pos    = out_rec.pos;
  assign out_line_number  = out_rec.line;
  assign out_token_length = out_rec.len;
  assign out_int_value    = out_rec.ival;
  assign out_char_value   = out_rec.cval;
  assign out_last_result  = out_rec.last;

endmodule
